// File: rtl/core/ffha_pkg.sv
// ============================================================================
// ffha_pkg
// Shared types, field widths and the control store of the first-fit heap
// allocator sequencer.
// ============================================================================
package ffha_pkg;

  // Field widths of the stream words and the config register
  localparam int unsigned REQ_W      = 16;
  localparam int unsigned FOFF_W     = 12;
  localparam int unsigned BOFF_W     = 12;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 16;
  // Rounded request: up to 65536, one bit wider than the request
  localparam int unsigned WANT_W     = REQ_W + 1;

  // Allocator constants
  localparam int unsigned HDR_BYTES   = 8;
  localparam int unsigned SPLIT_SLACK = 12;
  localparam int unsigned MIN_ALLOC   = 8;
  localparam int unsigned MIN_HEAP    = 16;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [0:0] {
    ST_DONE  = 1'b0,
    ST_NOFIT = 1'b1
  } status_e;

  // Control store addresses
  typedef enum logic [3:0] {
    S_INIT      = 4'd0,
    S_IDLE      = 4'd1,
    S_DISPATCH  = 4'd2,
    S_WALK_RD   = 4'd3,
    S_WALK_CHK  = 4'd4,
    S_ADV       = 4'd5,
    S_SPLIT     = 4'd6,
    S_WR_NEW    = 4'd7,
    S_WR_HDR    = 4'd8,
    S_DONE      = 4'd9,
    S_NOFIT     = 4'd10,
    S_FREE_RD   = 4'd11,
    S_FREE_WR   = 4'd12,
    S_FREE_DONE = 4'd13
  } step_e;

  // Branch conditions
  typedef enum logic [2:0] {
    C_ALWAYS    = 3'd0,
    C_IN_FIRE   = 3'd1,
    C_IS_FREE   = 3'd2,
    C_POS_END   = 3'd3,
    C_FIT       = 3'd4,
    C_NO_SPLIT  = 3'd5,
    C_FREE_SKIP = 3'd6,
    C_OUT_FREE  = 3'd7
  } cond_e;

  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_POS  = 2'd1,
    RD_FREE = 2'd2
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE  = 3'd0,
    WR_INIT  = 3'd1,
    WR_SPLIT = 3'd2,
    WR_HDR   = 3'd3,
    WR_FREE  = 3'd4
  } wr_sel_e;

  typedef enum logic [1:0] {
    OUT_NONE  = 2'd0,
    OUT_OK    = 2'd1,
    OUT_NOFIT = 2'd2,
    OUT_FREED = 2'd3
  } out_sel_e;

  // One control word: branch on cond to target, else hold or fall through
  typedef struct packed {
    cond_e    cond;
    logic     hold;
    step_e    target;
    rd_sel_e  rd;
    wr_sel_e  wr;
    logic     ld_size;
    logic     size_want;
    logic     pos_adv;
    out_sel_e out;
  } uword_t;

  // Control store
  function automatic uword_t ucode_rom(step_e step);
    uword_t w;
    begin
      w = '{cond: C_ALWAYS, hold: 1'b0, target: S_IDLE, rd: RD_NONE, wr: WR_NONE,
            ld_size: 1'b0, size_want: 1'b0, pos_adv: 1'b0, out: OUT_NONE};
      case (step)
        S_INIT: begin
          w.wr = WR_INIT;
        end
        S_IDLE: begin
          w.cond = C_IN_FIRE; w.hold = 1'b1; w.target = S_DISPATCH;
        end
        S_DISPATCH: begin
          w.cond = C_IS_FREE; w.target = S_FREE_RD;
        end
        S_WALK_RD: begin
          w.cond = C_POS_END; w.target = S_NOFIT; w.rd = RD_POS;
        end
        S_WALK_CHK: begin
          w.cond = C_FIT; w.target = S_SPLIT; w.ld_size = 1'b1;
        end
        S_ADV: begin
          w.target = S_WALK_RD; w.pos_adv = 1'b1;
        end
        S_SPLIT: begin
          w.cond = C_NO_SPLIT; w.target = S_WR_HDR;
        end
        S_WR_NEW: begin
          w.cond = C_ALWAYS; w.target = S_WR_HDR; w.wr = WR_SPLIT; w.size_want = 1'b1;
        end
        S_WR_HDR: begin
          w.target = S_DONE; w.wr = WR_HDR;
        end
        S_DONE: begin
          w.cond = C_OUT_FREE; w.hold = 1'b1; w.out = OUT_OK;
        end
        S_NOFIT: begin
          w.cond = C_OUT_FREE; w.hold = 1'b1; w.out = OUT_NOFIT;
        end
        S_FREE_RD: begin
          w.cond = C_FREE_SKIP; w.target = S_FREE_DONE; w.rd = RD_FREE;
        end
        S_FREE_WR: begin
          w.target = S_FREE_DONE; w.wr = WR_FREE;
        end
        S_FREE_DONE: begin
          w.cond = C_OUT_FREE; w.hold = 1'b1; w.out = OUT_FREED;
        end
        default: begin
          w.target = S_IDLE;
        end
      endcase
      return w;
    end
  endfunction

endpackage

// File: rtl/core/first_fit_heap_allocator_unit.sv
// ============================================================================
// first_fit_heap_allocator_unit
// First-fit heap allocator with chunk splitting. Chunk headers live in a
// word-indexed memory; a small control store sequences walks and updates.
// ============================================================================
//
//  channel  | direction | tdata / data                          | tuser
//  ---------+-----------+---------------------------------------+--------
//  s_axis   | in        | [15:0] request_bytes, [27:16] free_off | opcode
//  m_axis   | out       | [11:0] block_offset                   | status
//  cfg      | in        | [12:0] heap_bytes                     | -
//
//  Allocate: walk the chunk headers, each read then checked, to the first fit;
//  split it when large enough and mark it used. Reads use the single read port
//  and registered read data of the header memory. Free: read, then free a valid offset.
//  One item is in work at a time. After reset, the init step writes the initial
//  free chunk before input opens. A finished word waits in the output register;
//  the next input is taken meanwhile, and a new result waits in its step until
//  the register empties.
module first_fit_heap_allocator_unit #(
  parameter int unsigned HEAP_BYTES = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input words
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [ffha_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // request_bytes, free_offset
  input  logic                               s_axis_tuser,  // opcode
  // result words
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [ffha_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // block_offset
  output logic                               m_axis_tuser,  // status
  // heap size register
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ffha_pkg::CFG_W-1:0]         cfg_data_i
);
  import ffha_pkg::*;

  localparam int unsigned WORDS      = HEAP_BYTES / 4;
  localparam int unsigned AW         = $clog2(WORDS);
  localparam int unsigned SW         = $clog2(HEAP_BYTES);
  localparam int unsigned EW         = SW + 1;
  localparam int unsigned HW         = SW + 1;
  localparam int unsigned PW         = HW + 1;
  localparam int unsigned RESET_HEAP = (HEAP_BYTES < 4096) ? HEAP_BYTES : 4096;

  // Sequencer and datapath registers
  step_e               upc_q, upc_d;
  logic [HW-1:0]       heap_q;
  logic [PW-1:0]       pos_q;
  logic [SW-1:0]       size_q;
  opcode_e             op_q;
  logic [REQ_W-1:0]    req_q;
  logic [FOFF_W-1:0]   off_q;
  logic [EW-1:0]       rdata_q;
  logic [EW-1:0]       hdr_mem_q [WORDS];
  logic                out_valid_q;
  logic [BOFF_W-1:0]   out_offset_q;
  status_e             out_status_q;

  uword_t              uw;
  logic                in_fire, cfg_fire, out_free, cond_true;
  logic [WANT_W-1:0]   want_raw, want, new_size_w;
  logic                rd_used, fit, split, pos_end, free_ok, npos_ok;
  logic [SW-1:0]       rd_size;
  logic [PW-1:0]       npos;
  logic [31:0]         fidx32, cfg32, boff32;
  logic [HW-1:0]       cfg_heap;
  logic                rd_en, we;
  logic [AW-1:0]       raddr, waddr;
  logic [EW-1:0]       wdata;

  assign uw            = ucode_rom(upc_q);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready = (upc_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Request rounding: up to a multiple of four, at least the minimum block
  assign want_raw = (WANT_W'(req_q) + WANT_W'(3)) & ~WANT_W'(3);
  assign want     = (want_raw < WANT_W'(MIN_ALLOC)) ? WANT_W'(MIN_ALLOC) : want_raw;

  // Walk tests on the header just read
  assign rd_used    = rdata_q[SW];
  assign rd_size    = rdata_q[SW-1:0];
  assign fit        = !rd_used && (WANT_W'(rd_size) >= want);
  assign split      = WANT_W'(size_q) > (want + WANT_W'(HDR_BYTES + SPLIT_SLACK));
  assign pos_end    = pos_q >= PW'(heap_q);
  assign npos       = pos_q + PW'(HDR_BYTES) + PW'(want);
  assign npos_ok    = npos < PW'(WORDS * 4);
  assign new_size_w = WANT_W'(size_q) - want - WANT_W'(HDR_BYTES);

  // Free target: header one header length below the data offset
  assign fidx32  = 32'(off_q[FOFF_W-1:2]) - 32'd2;
  assign free_ok = (off_q >= FOFF_W'(HDR_BYTES)) && (fidx32 < 32'(WORDS));

  // Config value: drop low bits, clamp to the heap range
  always_comb begin
    cfg32 = 32'(cfg_data_i) & ~32'd3;
    if (cfg32 > 32'(HEAP_BYTES)) cfg32 = 32'(HEAP_BYTES);
    if (cfg32 < 32'(MIN_HEAP))   cfg32 = 32'(MIN_HEAP);
    cfg_heap = cfg32[HW-1:0];
  end

  // Branch condition select
  always_comb begin
    case (uw.cond)
      C_ALWAYS:    cond_true = 1'b1;
      C_IN_FIRE:   cond_true = in_fire;
      C_IS_FREE:   cond_true = (op_q == OP_FREE);
      C_POS_END:   cond_true = pos_end;
      C_FIT:       cond_true = fit;
      C_NO_SPLIT:  cond_true = !split;
      C_FREE_SKIP: cond_true = !free_ok;
      C_OUT_FREE:  cond_true = out_free;
      default:     cond_true = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    if (cond_true)    upc_d = uw.target;
    else if (uw.hold) upc_d = upc_q;
    else              upc_d = step_e'(upc_q + 4'd1);
  end

  // Memory port controls
  always_comb begin
    rd_en = 1'b0;
    raddr = pos_q[AW+1:2];
    case (uw.rd)
      RD_POS:  rd_en = 1'b1;
      RD_FREE: begin rd_en = 1'b1; raddr = fidx32[AW-1:0]; end
      default: rd_en = 1'b0;
    endcase

    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cfg_fire) begin
      we    = 1'b1;
      wdata = {1'b0, SW'(cfg_heap - HW'(HDR_BYTES))};
    end else begin
      case (uw.wr)
        WR_INIT: begin
          we    = 1'b1;
          wdata = {1'b0, SW'(heap_q - HW'(HDR_BYTES))};
        end
        WR_SPLIT: begin
          we    = npos_ok;
          waddr = npos[AW+1:2];
          wdata = {1'b0, new_size_w[SW-1:0]};
        end
        WR_HDR: begin
          we    = 1'b1;
          waddr = pos_q[AW+1:2];
          wdata = {1'b1, size_q};
        end
        WR_FREE: begin
          we    = 1'b1;
          waddr = fidx32[AW-1:0];
          wdata = {1'b0, rd_size};
        end
        default: we = 1'b0;
      endcase
    end
  end

  // Header memory
  always_ff @(posedge clk_i) begin
    if (we) hdr_mem_q[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= hdr_mem_q[raddr];
  end

  // Step counter and heap size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q  <= S_INIT;
      heap_q <= HW'(RESET_HEAP);
    end else begin
      upc_q <= upc_d;
      if (cfg_fire) heap_q <= cfg_heap;
    end
  end

  // Item registers and walk position
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= opcode_e'(s_axis_tuser);
      req_q <= s_axis_tdata[REQ_W-1:0];
      off_q <= s_axis_tdata[REQ_W+FOFF_W-1:REQ_W];
      pos_q <= '0;
    end else if (uw.pos_adv) begin
      pos_q <= pos_q + PW'(HDR_BYTES) + PW'(size_q);
    end
    if (uw.ld_size)        size_q <= rd_size;
    else if (uw.size_want) size_q <= want[SW-1:0];
  end

  // Result register
  assign boff32 = 32'(pos_q) + 32'(HDR_BYTES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uw.out != OUT_NONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uw.out != OUT_NONE && out_free) begin
      case (uw.out)
        OUT_OK: begin
          out_offset_q <= boff32[BOFF_W-1:0];
          out_status_q <= ST_DONE;
        end
        OUT_NOFIT: begin
          out_offset_q <= '0;
          out_status_q <= ST_NOFIT;
        end
        default: begin
          out_offset_q <= '0;
          out_status_q <= ST_DONE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_offset_q);
  assign m_axis_tuser  = out_status_q;

  // Checks
  a_pos_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q[1:0] == 2'b00 || upc_q == S_INIT || upc_q == S_IDLE)
    else $error("walk position not word aligned");

  a_heap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heap_q >= HW'(MIN_HEAP) && heap_q <= HW'(HEAP_BYTES) && heap_q[1:0] == 2'b00)
    else $error("heap size out of range");

  a_nofit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_NOFIT) |-> m_axis_tdata == '0)
    else $error("no-fit result carries an offset");

  a_seq_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.wr == WR_SPLIT || uw.wr == WR_HDR || uw.wr == WR_FREE) |-> !s_axis_tready)
    else $error("header update while input is open");

endmodule
